/* hw/rtl/linear_index_to_subscripts_assert.svh */
// Assertion macros for the linear index to subscripts block.
`ifndef LINEAR_INDEX_TO_SUBSCRIPTS_ASSERT_SVH
`define LINEAR_INDEX_TO_SUBSCRIPTS_ASSERT_SVH
`ifndef SYNTH
`define LIS_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("implication check failed");
`define LIS_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("next-cycle check failed");
`else
`define LIS_ASSERT_IMPL(label, clk, rst_n, a, c)
`define LIS_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

/* hw/rtl/lis_pkg.sv */
// Shared constants for the linear index to subscripts block.
package lis_pkg;
    localparam int NUM_SUB         = 4;
    localparam int DEF_MAX_DIMS    = 4;
    localparam int DEF_INDEX_WIDTH = 32;
    localparam int SIZE_W          = 32;
    localparam int CNT_W           = 3;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_DIM_COUNT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SIZE_DIM0 = 3'd1;
endpackage

/* hw/rtl/lis_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module lis_div_pipe #(
    parameter int DW     = 32,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [DW-1:0]     dividend,
    input  logic [DW-1:0]     divisor,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [DW-1:0]     quot,
    output logic [DW-1:0]     rem,
    output logic [SIDE_W-1:0] out_side
);
    logic              valid_reg [DW];
    logic [DW-1:0]     rem_reg  [DW];
    logic [DW-1:0]     q_reg    [DW];
    logic [SIDE_W-1:0] side_reg [DW];

    genvar s;
    generate
        for (s = 0; s < DW; s++) begin : g_stage
            logic          v_prev;
            logic [DW-1:0] r_prev;
            logic [DW-1:0] q_prev;
            logic [SIDE_W-1:0] sd_prev;
            logic [DW:0]   trial;
            logic [DW:0]   diff;
            logic [DW-1:0] rem_next;
            logic [DW-1:0] q_next;

            if (s == 0) begin : g_first
                assign v_prev  = in_valid;
                assign r_prev  = '0;
                assign q_prev  = dividend;
                assign sd_prev = in_side;
            end else begin : g_rest
                assign v_prev  = valid_reg[s-1];
                assign r_prev  = rem_reg[s-1];
                assign q_prev  = q_reg[s-1];
                assign sd_prev = side_reg[s-1];
            end

            always_comb
            begin
                trial = {r_prev, q_prev[DW-1]};
                diff  = trial - {1'b0, divisor};
                if (trial >= {1'b0, divisor})
                begin
                    rem_next = diff[DW-1:0];
                    q_next   = {q_prev[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[DW-1:0];
                    q_next   = {q_prev[DW-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else
                begin
                    valid_reg[s] <= v_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[s]  <= rem_next;
                q_reg[s]    <= q_next;
                side_reg[s] <= sd_prev;
            end
        end
    endgenerate

    assign out_valid = valid_reg[DW-1];
    assign quot      = q_reg[DW-1];
    assign rem       = rem_reg[DW-1];
    assign out_side  = side_reg[DW-1];
endmodule

/* hw/rtl/linear_index_to_subscripts.sv */
// Top level: column-major linear index to subscripts converter.
// Usage:
//   Raise start with linear_index; the item is taken when busy is low.
//   busy never rises, so one item can be taken in every cycle.
//   Each result appears on subscript0..3 and beyond_end for one cycle
//   with done high; the receiver must take it then, it cannot stall.
//   D = min(MAX_DIMS, 4) and W = max(INDEX_WIDTH, 32). The pipeline is
//   one input register, a W-bit restoring divider per leading dimension
//   retiring one quotient bit per stage, and an output register.
//   Throughput: one item per cycle.
//   Configuration: cfg_we, cfg_addr, cfg_wdata write one register per
//   cycle: 0 dim_count, 1..4 size_dim0..3. Write only while idle.
//   Reset empties the pipeline and sets dim_count to 2, sizes to 1.
//   dim_count outside 2..D is clamped; a size of 0 acts as 1.
//   Subscripts past the used dimensions read 0. beyond_end marks an
//   index at or past the element count; the last used subscript then
//   holds the raw quotient.
`include "linear_index_to_subscripts_assert.svh"

module linear_index_to_subscripts #(
    parameter int MAX_DIMS    = lis_pkg::DEF_MAX_DIMS,
    parameter int INDEX_WIDTH = lis_pkg::DEF_INDEX_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [INDEX_WIDTH-1:0]           linear_index,
    input  logic                             cfg_we,
    input  logic [lis_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [lis_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output logic                             done,
    output logic [INDEX_WIDTH-1:0]           subscript0,
    output logic [INDEX_WIDTH-1:0]           subscript1,
    output logic [INDEX_WIDTH-1:0]           subscript2,
    output logic [INDEX_WIDTH-1:0]           subscript3,
    output logic                             beyond_end
);
    localparam int USED = (MAX_DIMS < lis_pkg::NUM_SUB) ? MAX_DIMS : lis_pkg::NUM_SUB;
    localparam int NDIV = USED - 1;
    localparam int IW   = INDEX_WIDTH;
    localparam int DW   = (IW > lis_pkg::SIZE_W) ? IW : lis_pkg::SIZE_W;
    localparam int SW   = lis_pkg::NUM_SUB * IW + DW;
    localparam int LAT  = NDIV * DW + 2;
    localparam int CW   = lis_pkg::CNT_W;

    typedef logic [lis_pkg::NUM_SUB-1:0][IW-1:0] subs_t;

    logic [CW-1:0]             dim_count_reg;
    logic [lis_pkg::SIZE_W-1:0] size_reg [USED];
    logic [DW-1:0]             ext [USED];
    logic [CW-1:0]             n_dims;
    logic [CW-1:0]             n_m1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_count_reg <= CW'(2);
            for (int i = 0; i < USED; i++)
            begin
                size_reg[i] <= lis_pkg::SIZE_W'(1);
            end
        end
        else if (cfg_we)
        begin
            if (cfg_addr == lis_pkg::REG_DIM_COUNT)
            begin
                dim_count_reg <= cfg_wdata[CW-1:0];
            end
            for (int i = 0; i < USED; i++)
            begin
                if (cfg_addr == lis_pkg::REG_SIZE_DIM0 + lis_pkg::CFG_ADDR_W'(i))
                begin
                    size_reg[i] <= cfg_wdata[lis_pkg::SIZE_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        if (dim_count_reg < CW'(2))
        begin
            n_dims = CW'(2);
        end
        else if (dim_count_reg > CW'(USED))
        begin
            n_dims = CW'(USED);
        end
        else
        begin
            n_dims = dim_count_reg;
        end
        n_m1 = n_dims - CW'(1);
        for (int i = 0; i < USED; i++)
        begin
            ext[i] = (size_reg[i] == '0) ? DW'(1) : DW'(size_reg[i]);
        end
    end

    assign busy = 1'b0;

    // input register
    logic          in_v_reg;
    logic [DW-1:0] in_k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        in_k_reg <= DW'(linear_index);
    end

    // divider chain
    logic          ch_v    [NDIV+1];
    logic [DW-1:0] ch_k    [NDIV+1];
    subs_t         ch_subs [NDIV+1];

    assign ch_v[0]    = in_v_reg;
    assign ch_k[0]    = in_k_reg;
    assign ch_subs[0] = '0;

    genvar j;
    generate
        for (j = 0; j < NDIV; j++) begin : g_dim
            logic          dv;
            logic [DW-1:0] dq;
            logic [DW-1:0] dr;
            logic [SW-1:0] dside;
            subs_t         dsubs;
            logic [DW-1:0] dk;
            logic          act;

            lis_div_pipe #(
                .DW     (DW),
                .SIDE_W (SW)
            ) u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (ch_v[j]),
                .dividend  (ch_k[j]),
                .divisor   (ext[j]),
                .in_side   ({ch_subs[j], ch_k[j]}),
                .out_valid (dv),
                .quot      (dq),
                .rem       (dr),
                .out_side  (dside)
            );

            assign act = CW'(j) < n_m1;
            assign dk  = dside[DW-1:0];

            always_comb
            begin
                dsubs = dside[SW-1:DW];
                if (act)
                begin
                    dsubs[j] = dr[IW-1:0];
                end
            end

            assign ch_v[j+1]    = dv;
            assign ch_k[j+1]    = act ? dq : dk;
            assign ch_subs[j+1] = dsubs;
        end
    endgenerate

    // last dimension and output register
    logic          f_beyond;
    subs_t         f_subs;
    logic [DW-1:0] f_last;
    logic          done_reg;
    subs_t         subs_reg;
    logic          beyond_reg;

    always_comb
    begin
        f_last = ext[0];
        f_subs = ch_subs[NDIV];
        for (int i = 0; i < USED; i++)
        begin
            if (CW'(i) == n_m1)
            begin
                f_last    = ext[i];
                f_subs[i] = ch_k[NDIV][IW-1:0];
            end
        end
        f_beyond = ch_k[NDIV] >= f_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ch_v[NDIV];
        end
    end

    always_ff @(posedge clk)
    begin
        subs_reg   <= f_subs;
        beyond_reg <= f_beyond;
    end

    assign done       = done_reg;
    assign subscript0 = subs_reg[0];
    assign subscript1 = subs_reg[1];
    assign subscript2 = subs_reg[2];
    assign subscript3 = subs_reg[3];
    assign beyond_end = beyond_reg;

    `LIS_ASSERT_IMPL(a_done_latency, clk, rst_n, done, $past(start && !busy, LAT))
    `LIS_ASSERT_IMPL(a_unused_zero, clk, rst_n, done && n_dims == CW'(2),
        subscript2 == '0 && subscript3 == '0)
    `LIS_ASSERT_NEXT(a_result_follows, clk, rst_n, ch_v[NDIV], done)
endmodule

/* tb/linear_index_to_subscripts_tb.sv */
// Testbench for linear_index_to_subscripts: directed table plus random indices, checked against a predictor.
module linear_index_to_subscripts_tb;
    localparam int LATENCY = 98;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_RANDOM = 700;

    typedef struct packed {
        logic [31:0] s0;
        logic [31:0] s1;
        logic [31:0] s2;
        logic [31:0] s3;
        logic        beyond;
    } subs_t;

    typedef struct {
        logic [31:0] idx;
        logic        known;
        subs_t       want;
    } vec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [31:0] linear_index = '0;
    logic cfg_we = 1'b0;
    logic [lis_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [lis_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic busy, done, beyond_end;
    logic [31:0] subscript0, subscript1, subscript2, subscript3;

    logic [2:0]  cur_count;
    logic [31:0] cur_size [4];
    subs_t expected_subs [$];
    int errors = 0;
    int idle_cycles = 0;

    linear_index_to_subscripts dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .linear_index(linear_index), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata), .done(done), .subscript0(subscript0),
        .subscript1(subscript1), .subscript2(subscript2),
        .subscript3(subscript3), .beyond_end(beyond_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic subs_t split_index(logic [31:0] idx);
        logic [31:0] k;
        logic [31:0] e;
        logic [31:0] sub [4];
        int n;
        subs_t r;
        k = idx;
        n = (cur_count < 2) ? 2 : ((cur_count > 4) ? 4 : int'(cur_count));
        for (int j = 0; j < 4; j++)
            sub[j] = '0;
        for (int j = 0; j < n - 1; j++)
        begin
            e = (cur_size[j] == 0) ? 32'd1 : cur_size[j];
            sub[j] = k % e;
            k = k / e;
        end
        e = (cur_size[n-1] == 0) ? 32'd1 : cur_size[n-1];
        r.beyond = (k >= e);
        sub[n-1] = r.beyond ? k : k % e;
        r.s0 = sub[0];
        r.s1 = sub[1];
        r.s2 = sub[2];
        r.s3 = sub[3];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        subs_t w;
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (done)
        begin
            if (expected_subs.size() == 0)
                report_mismatch("unexpected result", subscript0, 32'h0);
            else
            begin
                w = expected_subs.pop_front();
                if (subscript0 !== w.s0) report_mismatch("subscript0", subscript0, w.s0);
                if (subscript1 !== w.s1) report_mismatch("subscript1", subscript1, w.s1);
                if (subscript2 !== w.s2) report_mismatch("subscript2", subscript2, w.s2);
                if (subscript3 !== w.s3) report_mismatch("subscript3", subscript3, w.s3);
                if (beyond_end !== w.beyond)
                    report_mismatch("beyond_end", {31'd0, beyond_end}, {31'd0, w.beyond});
            end
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(logic [lis_pkg::CFG_ADDR_W-1:0] a, logic [31:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (a == lis_pkg::REG_DIM_COUNT)
            cur_count = v[2:0];
        else
            cur_size[2'(a - lis_pkg::REG_SIZE_DIM0)] = v;
    endtask

    task automatic set_shape(logic [31:0] cnt, logic [31:0] a, logic [31:0] b,
                             logic [31:0] c, logic [31:0] d);
        write_reg(lis_pkg::REG_DIM_COUNT, cnt);
        write_reg(lis_pkg::REG_SIZE_DIM0, a);
        write_reg(lis_pkg::REG_SIZE_DIM0 + 3'd1, b);
        write_reg(lis_pkg::REG_SIZE_DIM0 + 3'd2, c);
        write_reg(lis_pkg::REG_SIZE_DIM0 + 3'd3, d);
    endtask

    task automatic wait_drained();
        while (expected_subs.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // called at a falling edge; returns at a falling edge with start still high
    task automatic send_index(logic [31:0] idx, logic known, subs_t want);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        linear_index <= idx;
        @(posedge clk);
        while (busy) @(posedge clk);
        expected_subs.push_back(known ? want : split_index(idx));
        @(negedge clk);
    endtask

    task automatic run_random(int count);
        logic [31:0] idx;
        logic [31:0] span;
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 3);
            span = cur_size[0] * cur_size[1] * cur_size[2] * cur_size[3];
            if (pick == 0)
                idx = $urandom();
            else if (pick == 1 && span != 0)
                idx = span - 1 + $urandom_range(0, 2);
            else if (span == 0 || span == 32'hFFFFFFFF)
                idx = $urandom();
            else
                idx = $urandom() % (span + 1);
            send_index(idx, 1'b0, '0);
        end
        start <= 1'b0;
    endtask

    vec_t dir_vecs [5] = '{
        '{32'd0,          1'b1, '{32'd0, 32'd0, 32'd0, 32'd0, 1'b0}},
        '{32'd1,          1'b1, '{32'd0, 32'd1, 32'd0, 32'd0, 1'b1}},
        '{32'hFFFFFFFF,   1'b1, '{32'd0, 32'hFFFFFFFF, 32'd0, 32'd0, 1'b1}},
        '{32'h55555555,   1'b0, '{32'd0, 32'd0, 32'd0, 32'd0, 1'b0}},
        '{32'hAAAAAAAA,   1'b0, '{32'd0, 32'd0, 32'd0, 32'd0, 1'b0}}
    };

    initial
    begin
        cur_count = 3'd2;
        for (int i = 0; i < 4; i++)
            cur_size[i] = 32'd1;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset shape: sizes all 1, two dims
        foreach (dir_vecs[i])
            send_index(dir_vecs[i].idx, dir_vecs[i].known, dir_vecs[i].want);
        start <= 1'b0;
        wait_drained();

        // dim count clamped below, zero extents
        set_shape(0, 0, 5, 0, 0);
        foreach (dir_vecs[i]) send_index(dir_vecs[i].idx, 1'b0, '0);
        send_index(32'd4, 1'b0, '0);
        send_index(32'd5, 1'b0, '0);
        start <= 1'b0;
        wait_drained();

        // dim count clamped above, max extents
        set_shape(7, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        foreach (dir_vecs[i]) send_index(dir_vecs[i].idx, 1'b0, '0);
        send_index(32'hFFFFFFFE, 1'b0, '0);
        start <= 1'b0;
        wait_drained();

        set_shape(4, 3, 5, 7, 2);
        send_index(32'd209, 1'b0, '0);
        send_index(32'd210, 1'b0, '0);
        run_random(NUM_RANDOM / 4);
        wait_drained();

        set_shape(3, $urandom_range(1, 300), $urandom_range(1, 300),
                  $urandom_range(1, 300), $urandom());
        run_random(NUM_RANDOM / 4);
        wait_drained();

        set_shape(2, $urandom_range(1, 70000), $urandom_range(1, 70000), 9, 9);
        run_random(NUM_RANDOM / 4);
        wait_drained();

        set_shape(4, $urandom(), $urandom_range(1, 16), $urandom(), $urandom());
        run_random(NUM_RANDOM / 4);
        wait_drained();

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
